@@ hdl/brme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brme_pkg
// Types and constants shared by the byte register machine executor.
// ----------------------------------------------------------------------------
package brme_pkg;

  localparam int PROGRAM_DEPTH_DEF = 256;
  localparam int REG_COUNT         = 16;
  localparam int REG_AW            = 4;

  localparam logic [7:0] OP_INC  = 8'h01;
  localparam logic [7:0] OP_DEC  = 8'h02;
  localparam logic [7:0] OP_MOV  = 8'h03;
  localparam logic [7:0] OP_LDI  = 8'h04;
  localparam logic [7:0] OP_SHL  = 8'h05;
  localparam logic [7:0] OP_SHR  = 8'h06;
  localparam logic [7:0] OP_JMP  = 8'h07;
  localparam logic [7:0] OP_JZ   = 8'h08;
  localparam logic [7:0] OP_JNZ  = 8'h09;
  localparam logic [7:0] OP_JEND = 8'h0A;
  localparam logic [7:0] OP_HALT = 8'h0B;
  localparam logic [7:0] OP_ADD  = 8'h0C;
  localparam logic [7:0] OP_SUB  = 8'h0D;
  localparam logic [7:0] OP_XOR  = 8'h0E;
  localparam logic [7:0] OP_OR   = 8'h0F;
  localparam logic [7:0] OP_READ = 8'h10;
  localparam logic [7:0] OP_WRT  = 8'h11;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] input_byte;
    logic       input_available;
  } brme_in_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       write_valid;
    logic [7:0] write_byte;
    logic       halted;
  } brme_out_t;

endpackage

@@ hdl/byte_register_machine_executor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_register_machine_executor
// Executes one two-byte instruction per transaction on sixteen 8-bit
// registers and returns the next pc, an optional output byte and halt status.
// ----------------------------------------------------------------------------
// pipeline: an instruction is registered in stage 1 (register file read), then in the output stage
// throughput: 1 instruction per cycle while out_stall is low, set by the register file read,
//   alu and write-back path with write-to-read forwarding
// reset: synchronous active-low rst_n clears registers (valid bits), flags,
//   pc and both pipeline valids; no clearing pass
module byte_register_machine_executor
  import brme_pkg::*;
#(
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  brme_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output brme_out_t out_data
);

  localparam int PC_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

  // jump distance reduced modulo program depth, per operand value
  logic [PC_W-1:0] jmp_mod [256];

  for (genvar g = 0; g < 256; g++) begin : g_jmp
    localparam int SOFF = (g >= 128) ? g - 256 : g;
    localparam int HALF = SOFF / 2;
    localparam int MODV = ((HALF % PROGRAM_DEPTH) + PROGRAM_DEPTH) % PROGRAM_DEPTH;
    assign jmp_mod[g] = PC_W'(MODV);
  end

  // register file
  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] mem_vld_r;

  // stage 1
  logic        s1_valid_r;
  brme_in_t    s1_data_r;
  logic [7:0]  rd_lo_r;
  logic [7:0]  rd_hi_r;

  // architectural state
  logic [PC_W-1:0] pc_r;
  logic            zf_r;
  logic            ef_r;
  logic            halt_r;

  // output stage
  logic        out_valid_r;
  brme_out_t   out_data_r;

  logic        exec_fire;
  logic        in_fire;
  logic        we;
  logic [REG_AW-1:0] waddr;
  logic [7:0]  wdata;
  logic        take_jmp;
  logic        hold_pc;
  logic        setz;
  logic [7:0]  lo_new;
  logic        zf_nxt;
  logic        ef_nxt;
  logic        halt_nxt;
  logic [PC_W-1:0] pc_step;
  logic [PC_W:0]   pc_sum;
  logic [PC_W-1:0] pc_nxt;
  brme_out_t   res;
  logic [REG_AW-1:0] ra_lo;
  logic [REG_AW-1:0] ra_hi;
  logic [REG_AW-1:0] s1_lo;

  assign exec_fire = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !exec_fire;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ra_lo = in_data.operand[3:0];
  assign ra_hi = in_data.operand[7:4];
  assign s1_lo = s1_data_r.operand[3:0];

  // execute
  always_comb begin
    we       = 1'b0;
    waddr    = s1_lo;
    wdata    = rd_lo_r;
    take_jmp = 1'b0;
    hold_pc  = 1'b0;
    setz     = 1'b0;
    lo_new   = rd_lo_r;
    ef_nxt   = ef_r;
    halt_nxt = halt_r;
    res      = '0;
    unique case (s1_data_r.opcode)
      OP_INC: begin
        we    = 1'b1;
        wdata = rd_lo_r + 8'd1;
      end
      OP_DEC: begin
        we    = 1'b1;
        wdata = rd_lo_r - 8'd1;
      end
      OP_MOV: begin
        we    = 1'b1;
        wdata = rd_hi_r;
        setz  = 1'b1;
      end
      OP_LDI: begin
        we    = 1'b1;
        waddr = '0;
        wdata = s1_data_r.operand;
      end
      OP_SHL: begin
        we    = 1'b1;
        wdata = {rd_lo_r[6:0], 1'b0};
      end
      OP_SHR: begin
        we    = 1'b1;
        wdata = {1'b0, rd_lo_r[7:1]};
      end
      OP_JMP:  take_jmp = 1'b1;
      OP_JZ:   take_jmp = zf_r;
      OP_JNZ:  take_jmp = !zf_r;
      OP_JEND: take_jmp = ef_r;
      OP_HALT: begin
        halt_nxt = 1'b1;
        hold_pc  = 1'b1;
      end
      OP_ADD: begin
        we    = 1'b1;
        wdata = rd_lo_r + rd_hi_r;
        setz  = 1'b1;
      end
      OP_SUB: begin
        we    = 1'b1;
        wdata = rd_lo_r - rd_hi_r;
        setz  = 1'b1;
      end
      OP_XOR: begin
        we    = 1'b1;
        wdata = rd_lo_r ^ rd_hi_r;
        setz  = 1'b1;
      end
      OP_OR: begin
        we    = 1'b1;
        wdata = rd_lo_r | rd_hi_r;
        setz  = 1'b1;
      end
      OP_READ: begin
        setz = 1'b1;
        if (!ef_r) begin
          if (s1_data_r.input_available) begin
            we    = 1'b1;
            wdata = s1_data_r.input_byte;
          end else begin
            ef_nxt = 1'b1;
          end
        end
      end
      OP_WRT: begin
        res.write_valid = 1'b1;
        res.write_byte  = rd_lo_r;
      end
      default: ;
    endcase

    if (we && (waddr == s1_lo)) begin
      lo_new = wdata;
    end
    zf_nxt = setz ? (lo_new == 8'd0) : zf_r;

    if (hold_pc) begin
      pc_step = '0;
    end else if (take_jmp) begin
      pc_step = jmp_mod[s1_data_r.operand];
    end else begin
      pc_step = PC_W'(1 % PROGRAM_DEPTH);
    end
    pc_sum = {1'b0, pc_r} + {1'b0, pc_step};
    if (pc_sum >= (PC_W+1)'(PROGRAM_DEPTH)) begin
      pc_sum = pc_sum - (PC_W+1)'(PROGRAM_DEPTH);
    end
    pc_nxt = pc_sum[PC_W-1:0];

    if (halt_r) begin
      we       = 1'b0;
      zf_nxt   = zf_r;
      ef_nxt   = ef_r;
      halt_nxt = halt_r;
      pc_nxt   = pc_r;
      res      = '0;
    end
    res.next_pc = 8'(pc_nxt);
    res.halted  = halt_nxt;
  end

  // register file write
  always_ff @(posedge clk) begin
    if (exec_fire && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (exec_fire && we) begin
      mem_vld_r[waddr] <= 1'b1;
    end
  end

  // register file read with write-back forwarding
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
      if (exec_fire && we && (waddr == ra_lo)) begin
        rd_lo_r <= wdata;
      end else begin
        rd_lo_r <= mem_vld_r[ra_lo] ? mem[ra_lo] : 8'd0;
      end
      if (exec_fire && we && (waddr == ra_hi)) begin
        rd_hi_r <= wdata;
      end else begin
        rd_hi_r <= mem_vld_r[ra_hi] ? mem[ra_hi] : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      zf_r   <= 1'b0;
      ef_r   <= 1'b0;
      halt_r <= 1'b0;
    end else if (exec_fire) begin
      pc_r   <= pc_nxt;
      zf_r   <= zf_nxt;
      ef_r   <= ef_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
